FILE: rtl/bed_pkg.sv
// Shared types and constants for the backslash escape decoder.
`default_nettype none

package bed_pkg;

  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharX         = 8'h78;
  localparam logic [7:0] CharU         = 8'h75;
  localparam logic [7:0] CharN         = 8'h6E;
  localparam logic [7:0] CharR         = 8'h72;
  localparam logic [7:0] CharA         = 8'h61;
  localparam logic [7:0] CharB         = 8'h62;
  localparam logic [7:0] CharT         = 8'h74;
  localparam logic [7:0] CharV         = 8'h76;
  localparam logic [7:0] CharF         = 8'h66;
  localparam logic [7:0] CharZero      = 8'h30;
  // offset that maps 'a' onto ten
  localparam logic [7:0] LetterOffset  = CharA - 8'd10;

  localparam logic [7:0] CodeLf  = 8'h0A;
  localparam logic [7:0] CodeCr  = 8'h0D;
  localparam logic [7:0] CodeBel = 8'h07;
  localparam logic [7:0] CodeBs  = 8'h08;
  localparam logic [7:0] CodeTab = 8'h09;
  localparam logic [7:0] CodeVt  = 8'h0B;
  localparam logic [7:0] CodeFf  = 8'h0C;

  localparam int unsigned MaxBurst   = 3;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  typedef enum logic [2:0] {
    MODE_PLAIN  = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_X_HI   = 3'd2,
    MODE_X_LO   = 3'd3,
    MODE_U_HI1  = 3'd4,
    MODE_U_LO1  = 3'd5,
    MODE_U_HI2  = 3'd6,
    MODE_U_LO2  = 3'd7
  } bed_mode_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       final_char;
  } bed_in_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       is_terminator;
    logic       escape_cut_short;
  } bed_out_t;

  // results produced by one input beat, item[0] first
  typedef struct packed {
    logic [1:0]         cnt;
    bed_out_t [MaxBurst-1:0] item;
  } bed_burst_t;

  function automatic logic [7:0] digit_value(logic [7:0] c);
    return (c >= CharA) ? c - LetterOffset : c - CharZero;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bed_decode.sv
// Escape decoder state machine: turns one input beat into up to three results.
`default_nettype none

module bed_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  bed_pkg::bed_in_t in_data_i,
  output bed_pkg::bed_burst_t burst_o
);
  import bed_pkg::*;

  bed_mode_e  mode_q, mode_d, step_mode;
  logic [7:0] hi_q, hi_d;
  logic [7:0] c;
  logic [7:0] dv;

  assign c  = in_data_i.char_in;
  assign dv = digit_value(c);

  // next state
  always_comb begin
    step_mode = mode_q;
    hi_d      = hi_q;
    unique case (mode_q) inside
      MODE_PLAIN: begin
        if (c == CharBackslash) step_mode = MODE_ESC;
      end
      MODE_ESC: begin
        if (c == CharX)      step_mode = MODE_X_HI;
        else if (c == CharU) step_mode = MODE_U_HI1;
        else                 step_mode = MODE_PLAIN;
      end
      MODE_X_HI: begin
        hi_d      = {dv[3:0], 4'h0};
        step_mode = MODE_X_LO;
      end
      MODE_U_HI1: begin
        hi_d      = {dv[3:0], 4'h0};
        step_mode = MODE_U_LO1;
      end
      MODE_U_HI2: begin
        hi_d      = {dv[3:0], 4'h0};
        step_mode = MODE_U_LO2;
      end
      MODE_U_LO1: begin
        hi_d      = 8'h00;
        step_mode = MODE_U_HI2;
      end
      MODE_X_LO, MODE_U_LO2: begin
        hi_d      = 8'h00;
        step_mode = MODE_PLAIN;
      end
      default: step_mode = MODE_PLAIN;
    endcase
    mode_d = step_mode;
    if (in_data_i.final_char) begin
      mode_d = MODE_PLAIN;
      hi_d   = 8'h00;
    end
  end

  // results
  always_comb begin
    logic [7:0] b0, b1;
    logic [1:0] n;
    b0 = 8'h00;
    b1 = 8'h00;
    n  = 2'd0;
    unique case (mode_q) inside
      MODE_PLAIN: begin
        if (c != CharBackslash) begin
          b0 = c;
          n  = 2'd1;
        end
      end
      MODE_ESC: begin
        n = 2'd1;
        case (c) inside
          CharX, CharU: n = 2'd0;
          CharN: b0 = CodeLf;
          CharR: b0 = CodeCr;
          CharA: b0 = CodeBel;
          CharB: b0 = CodeBs;
          CharT: b0 = CodeTab;
          CharV: b0 = CodeVt;
          CharF: b0 = CodeFf;
          default: begin
            b0 = CharBackslash;
            b1 = c;
            n  = 2'd2;
          end
        endcase
      end
      MODE_X_LO, MODE_U_LO1, MODE_U_LO2: begin
        b0 = hi_q | dv;
        n  = 2'd1;
      end
      default: n = 2'd0;
    endcase

    burst_o = '0;
    burst_o.item[0].byte_out = b0;
    burst_o.item[1].byte_out = b1;
    if (in_data_i.final_char) begin
      // terminator lands right after the data results
      burst_o.item[n].byte_out         = 8'h00;
      burst_o.item[n].is_terminator    = 1'b1;
      burst_o.item[n].escape_cut_short = (step_mode != MODE_PLAIN);
      n = n + 2'd1;
    end
    burst_o.cnt = accept_i ? n : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      hi_q   <= 8'h00;
    end else if (accept_i) begin
      mode_q <= mode_d;
      hi_q   <= hi_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bed_queue.sv
// Result queue: takes up to three results per cycle, hands out one per beat.
`default_nettype none

module bed_queue #(
  parameter int unsigned Depth = bed_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bed_pkg::bed_burst_t burst_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bed_pkg::bed_out_t   out_data_o
);
  import bed_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bed_out_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  // room for a full burst, judged on the registered fill
  assign room_o      = (cnt_q <= CntW'(Depth - MaxBurst));

  assign cnt_d = cnt_q + CntW'(burst_i.cnt) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxBurst; k++) begin
      if (k < int'(burst_i.cnt)) begin
        mem_q[PtrW'((int'(wr_ptr_q) + k) % Depth)] <= burst_i.item[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= PtrW'((int'(wr_ptr_q) + int'(burst_i.cnt)) % Depth);
      if (pop) rd_ptr_q <= PtrW'((int'(rd_ptr_q) + 1) % Depth);
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/backslash_escape_decoder.sv
// Top level of the backslash escape decoder.
//
// Input channel: in_valid_i / in_ready_o, one text byte per beat, with
// final_char set on the last byte of a string. Output channel:
// out_valid_o / out_ready_i, one decoded byte per beat; every string ends
// with a terminator beat (byte 0, is_terminator set, escape_cut_short set
// when the string stopped inside an escape).
// A byte is decoded in the cycle it is accepted and its results (zero to
// three) are written into a small result queue; the first one shows on the
// output from the queue's registers once earlier results have left it.
// Throughput is one input byte per cycle while the output drains one beat
// per cycle. A byte that yields two or three results takes that many output
// beats, and the input is held off while the queue lacks room for a full
// burst of three.
// Reset clears the decode mode, the pending digit and the queue. When the
// receiver stalls the queue fills and in_ready_o drops until it drains.
`default_nettype none

module backslash_escape_decoder #(
  parameter int unsigned QueueDepth = bed_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bed_pkg::bed_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bed_pkg::bed_out_t out_data_o
);
  import bed_pkg::*;

  logic       accept;
  bed_burst_t burst;

  assign accept = in_valid_i && in_ready_o;

  bed_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .burst_o   (burst)
  );

  bed_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .burst_i     (burst),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: rtl/bed_checker.sv
// Port-level checks for the backslash escape decoder, bound to the top level.
`default_nettype none

module bed_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input bed_pkg::bed_out_t out_data_o
);
  import bed_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_cut_on_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.escape_cut_short |-> out_data_o.is_terminator)
    else $error("escape_cut_short outside a terminator");

  a_term_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_terminator |-> out_data_o.byte_out == 8'h00)
    else $error("terminator with nonzero byte");

  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("output appeared without an accepted input");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input held off with empty queue");

endmodule

bind backslash_escape_decoder bed_checker u_bed_checker (.*);

`default_nettype wire
